@@ hdl/brb_pkg.sv @@
// shared types, codes and sizes for the byte ring buffer with rewind
// used by brb_ctrl, brb_dp and the top level byte_ring_buffer_rewind
`timescale 1ns / 1ps

package brb_pkg;

    // storage and field sizes
    localparam int DEPTH     = 1024;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int MAX_BURST = 64;
    localparam int OP_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 11;
    localparam int ST_W      = 3;
    localparam int DONE_W    = 7;
    localparam int LVL_W     = 11;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 32;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_WR_BEGIN = 3'd0,
        OP_WR_BYTE  = 3'd1,
        OP_PEEK     = 3'd2,
        OP_POP      = 3'd3,
        OP_POP_MANY = 3'd4,
        OP_REWIND   = 3'd5
    } t_op;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_NOROOM  = 3'd2,
        ST_DROPPED = 3'd3,
        ST_BADLEN  = 3'd4
    } t_status;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;   // capture the input transfer
        logic exec;     // run the captured operation
        logic step;     // emit the next byte of a pop_many
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;     // output register can take a result this cycle
        logic start_burst;  // captured item is a pop_many that will stream bytes
        logic burst_end;    // current burst byte is the last one
    } t_sts;

    // bytes held: full depth when the full flag is set, else pointer distance
    function automatic logic [LVL_W-1:0] f_level(input logic full,
                                                 input logic [PTR_W-1:0] wp,
                                                 input logic [PTR_W-1:0] rp);
        logic [PTR_W-1:0] diff;
        diff = wp - rp;
        return full ? LVL_W'(DEPTH) : LVL_W'(diff);
    endfunction

endpackage

@@ hdl/brb_ctrl.sv @@
// controller state machine for the byte ring buffer
// depends on brb_pkg for the command and status structs
`timescale 1ns / 1ps

module brb_ctrl import brb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_BURST = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and command decode, no transfer is taken while in reset
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.start_burst ? S_BURST : S_IDLE;
                end
            end
            S_BURST: begin
                if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.burst_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/brb_dp.sv @@
// datapath of the byte ring buffer: byte memory, pointers, burst counters, result register
// depends on brb_pkg for sizes, codes, command/status structs and f_level
`timescale 1ns / 1ps

module brb_dp import brb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [OP_W-1:0]     i_op,
    input  logic [BYTE_W-1:0]   i_wr_byte,
    input  logic [CNT_W-1:0]    i_count,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [ST_W-1:0]     o_status,
    output logic [BYTE_W-1:0]   o_rd_byte,
    output logic [DONE_W-1:0]   o_count_done,
    output logic                o_last,
    output logic [LVL_W-1:0]    o_level
);

    // captured item
    logic [OP_W-1:0]   r_op;
    logic [BYTE_W-1:0] r_wb;
    logic [CNT_W-1:0]  r_cnt;

    // buffer state
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic              r_full, n_full;
    logic [CNT_W-1:0]  r_bl, n_bl;
    logic [DONE_W-1:0] r_left, n_left;
    logic [DONE_W-1:0] r_done, n_done;

    // byte memory and its registered read port
    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    logic              mem_we;

    // result register
    logic              r_out_valid;
    logic [ST_W-1:0]   r_out_status;
    logic [BYTE_W-1:0] r_out_data;
    logic [DONE_W-1:0] r_out_done;
    logic              r_out_last;
    logic [LVL_W-1:0]  r_out_level;

    logic              out_load;
    logic [ST_W-1:0]   res_status;
    logic [BYTE_W-1:0] res_data;
    logic [DONE_W-1:0] res_done;
    logic              res_last;
    logic [LVL_W-1:0]  cur_level;
    logic              start_burst;

    assign cur_level = f_level(r_full, r_wp, r_rp);

    // a pop_many that passes all checks with a nonzero count streams its bytes
    assign start_burst = (r_op == OP_POP_MANY) && (r_cnt <= CNT_W'(MAX_BURST))
                      && (cur_level != '0) && (cur_level >= r_cnt) && (r_cnt != '0);

    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.start_burst = start_burst;
    assign o_sts.burst_end   = (r_left == DONE_W'(1));

    // operation decode and next buffer state
    always_comb begin
        n_rp       = r_rp;
        n_wp       = r_wp;
        n_full     = r_full;
        n_bl       = r_bl;
        n_left     = r_left;
        n_done     = r_done;
        mem_we     = 1'b0;
        out_load   = 1'b0;
        res_status = ST_OK;
        res_data   = '0;
        res_done   = '0;
        res_last   = 1'b1;
        if (i_cmd.exec) begin
            out_load = !start_burst;
            case (r_op)
                OP_WR_BEGIN: begin
                    if (r_cnt > CNT_W'(DEPTH)) begin
                        res_status = ST_BADLEN;
                        n_bl       = '0;
                    end else if (!r_full && (r_cnt <= (LVL_W'(DEPTH) - cur_level))) begin
                        n_bl = r_cnt;
                    end else begin
                        res_status = ST_NOROOM;
                        n_bl       = '0;
                    end
                end
                OP_WR_BYTE: begin
                    if (r_bl == '0) begin
                        res_status = ST_NOROOM;
                    end else begin
                        n_bl = r_bl - CNT_W'(1);
                        if (r_full) begin
                            res_status = ST_DROPPED;
                        end else begin
                            mem_we = 1'b1;
                            n_wp   = r_wp + PTR_W'(1);
                            n_full = (n_wp == r_rp);
                        end
                    end
                end
                OP_PEEK, OP_POP: begin
                    if (cur_level == '0) begin
                        res_status = ST_EMPTY;
                    end else begin
                        res_data = r_rd_data;
                        if (r_op == OP_POP) begin
                            n_rp   = r_rp + PTR_W'(1);
                            n_full = 1'b0;
                        end
                    end
                end
                OP_POP_MANY: begin
                    if (r_cnt > CNT_W'(MAX_BURST)) begin
                        res_status = ST_BADLEN;
                    end else if ((cur_level == '0) || (cur_level < r_cnt)) begin
                        res_status = ST_EMPTY;
                    end else if (r_cnt != '0) begin
                        n_full = 1'b0;
                        n_left = r_cnt[DONE_W-1:0];
                        n_done = '0;
                    end
                end
                OP_REWIND: begin
                    if (r_cnt > CNT_W'(DEPTH)) begin
                        res_status = ST_BADLEN;
                    end else if (r_cnt != '0) begin
                        n_rp = r_rp - r_cnt[PTR_W-1:0];
                        if (n_rp == r_wp) begin
                            n_full = 1'b1;
                        end
                    end
                end
                default: begin
                    res_status = ST_BADLEN;
                end
            endcase
        end else if (i_cmd.step) begin
            // one byte of a pop_many
            out_load = 1'b1;
            res_data = r_rd_data;
            res_done = r_done + DONE_W'(1);
            res_last = (r_left == DONE_W'(1));
            n_rp     = r_rp + PTR_W'(1);
            n_done   = r_done + DONE_W'(1);
            n_left   = r_left - DONE_W'(1);
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_op;
            r_wb  <= i_wr_byte;
            r_cnt <= i_count;
        end
    end

    // pointers, full flag and burst counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp   <= '0;
            r_wp   <= '0;
            r_full <= 1'b0;
            r_bl   <= '0;
            r_left <= '0;
            r_done <= '0;
        end else begin
            r_rp   <= n_rp;
            r_wp   <= n_wp;
            r_full <= n_full;
            r_bl   <= n_bl;
            r_left <= n_left;
            r_done <= n_done;
        end
    end

    // byte memory, read address follows the next read pointer
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= r_wb;
        end
        r_rd_data <= r_mem[n_rp];
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= res_status;
            r_out_data   <= res_data;
            r_out_done   <= res_done;
            r_out_last   <= res_last;
            r_out_level  <= f_level(n_full, n_wp, n_rp);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_rd_byte    = r_out_data;
    assign o_count_done = r_out_done;
    assign o_last       = r_out_last;
    assign o_level      = r_out_level;

endmodule

@@ hdl/byte_ring_buffer_rewind.sv @@
// top level of the byte ring buffer with rewind
// depends on brb_pkg, brb_ctrl and brb_dp
//
// Usage:
//   The slave stream carries one command per transfer: tuser is the operation
//   (write_begin, write_byte, peek, pop, pop_many, rewind) and tdata holds the
//   byte to write and a count. The master stream returns results: tuser is the
//   status code, tdata holds the read byte, bytes delivered so far and the fill
//   level after the operation, and tlast marks the final result of a command.
// Command flow:
//   one command is worked on at a time. A single-result command is captured, then
//   executed into the output register once it is free, and its result shows
//   there in the cycle after execute. A pop_many streams one byte a cycle while
//   the output register is free, paced by the byte memory's single read port.
// Reset:
//   synchronous, active low. Pointers, full flag and burst count clear; the
//   byte memory is not cleared and reads of never written entries are undefined.
// Stalls:
//   results sit in an output register; while the receiver holds tready low the
//   block stops before loading the next result, and a new command is taken only
//   once the previous one has been fully handed to the output register.
`timescale 1ns / 1ps

module byte_ring_buffer_rewind import brb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // wr_byte[7:0], count[18:8], zero pad
    input  logic [OP_W-1:0]     s_axis_tuser,   // op[2:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // rd_byte[7:0], count_done[14:8],
                                                // level[25:15], zero pad
    output logic [ST_W-1:0]     m_axis_tuser,   // status[2:0]
    output logic                m_axis_tlast    // last
);

    t_cmd              cmd;
    t_sts              sts;
    logic [BYTE_W-1:0] rd_byte;
    logic [DONE_W-1:0] count_done;
    logic [LVL_W-1:0]  level;

    brb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    brb_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (s_axis_tuser),
        .i_wr_byte    (s_axis_tdata[BYTE_W-1:0]),
        .i_count      (s_axis_tdata[BYTE_W +: CNT_W]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_status     (m_axis_tuser),
        .o_rd_byte    (rd_byte),
        .o_count_done (count_done),
        .o_last       (m_axis_tlast),
        .o_level      (level)
    );

    // pack result fields
    assign m_axis_tdata = {{(M_DATA_W - BYTE_W - DONE_W - LVL_W){1'b0}},
                           level, count_done, rd_byte};

    // a captured command blocks the slave side until it is executed
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("command accepted while another is in progress");

    // results are loaded only into a free output register
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.exec || cmd.step) |-> sts.out_free)
        else $error("result loaded over a pending result");

    // every single-result execute and burst step shows up at the output
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cmd.exec && !sts.start_burst) || cmd.step) |=> m_axis_tvalid)
        else $error("result lost after execute");

    // no command capture while executing or streaming
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.exec || cmd.step) |-> !cmd.accept)
        else $error("capture overlaps execution");

endmodule

@@ test/tb_byte_ring_buffer_rewind.sv @@
// self-checking testbench for byte_ring_buffer_rewind: command stream in, result stream out
// depends on brb_pkg and the byte_ring_buffer_rewind rtl; carries its own ring buffer predictor
`timescale 1ns / 1ps

module tb_byte_ring_buffer_rewind;
    import brb_pkg::*;

    localparam int PAD_W        = S_DATA_W - BYTE_W - CNT_W;
    localparam int RANDOM_ITEMS = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PRINTS   = 40;

    // op codes outside the defined set
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    // one expected result transfer
    typedef struct {
        logic [ST_W-1:0]   st;
        logic [BYTE_W-1:0] data;
        logic [DONE_W-1:0] done;
        logic              last;
        logic [LVL_W-1:0]  lvl;
    } ring_rsp_t;

    // opening stimulus row; typed rows carry a status and level known up front
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] wb;
        logic [CNT_W-1:0]  cnt;
        logic              typed;
        logic [ST_W-1:0]   st;
        logic [LVL_W-1:0]  lvl;
    } opening_row_t;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;   // wr_byte[7:0], count[18:8], zero pad
    logic [OP_W-1:0]     s_axis_tuser  = '0;   // op[2:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;         // rd_byte[7:0], count_done[14:8], level[25:15]
    logic [ST_W-1:0]     m_axis_tuser;         // status[2:0]
    logic                m_axis_tlast;

    // predictor state
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    bit                ring_stamped [DEPTH];
    int                rd_idx;
    int                wr_idx;
    bit                is_full;
    int                burst_rem;

    ring_rsp_t due_results [$];
    ring_rsp_t item_head;
    int        item_results;

    int mismatches;
    int results_checked;
    int cmds_sent;
    int full_hits;
    int drops;
    int tx_run;
    int idle_cycles;

    opening_row_t opening_rows [26] = '{
        '{OP_PEEK,     8'h00, 11'd0,    1'b1, ST_EMPTY,   11'd0},
        '{OP_POP,      8'h00, 11'd0,    1'b1, ST_EMPTY,   11'd0},
        '{OP_POP_MANY, 8'h00, 11'd0,    1'b1, ST_EMPTY,   11'd0},
        '{OP_POP_MANY, 8'h00, 11'd65,   1'b1, ST_BADLEN,  11'd0},
        '{OP_WR_BYTE,  8'hAA, 11'd0,    1'b1, ST_NOROOM,  11'd0},
        '{OP_WR_BEGIN, 8'hFF, 11'd2047, 1'b1, ST_BADLEN,  11'd0},
        '{OP_REWIND,   8'h00, 11'd2047, 1'b1, ST_BADLEN,  11'd0},
        '{OP_REWIND,   8'h00, 11'd0,    1'b1, ST_OK,      11'd0},
        '{OP_SPARE_6,  8'h00, 11'd0,    1'b1, ST_BADLEN,  11'd0},
        '{OP_SPARE_7,  8'hFF, 11'd2047, 1'b1, ST_BADLEN,  11'd0},
        '{OP_WR_BEGIN, 8'h00, 11'd0,    1'b1, ST_OK,      11'd0},
        '{OP_WR_BYTE,  8'h11, 11'd0,    1'b1, ST_NOROOM,  11'd0},
        '{OP_WR_BEGIN, 8'h00, 11'd4,    1'b1, ST_OK,      11'd0},
        '{OP_WR_BYTE,  8'h00, 11'd0,    1'b1, ST_OK,      11'd1},
        '{OP_WR_BYTE,  8'hFF, 11'd0,    1'b1, ST_OK,      11'd2},
        '{OP_WR_BYTE,  8'h55, 11'd0,    1'b1, ST_OK,      11'd3},
        '{OP_WR_BYTE,  8'hAA, 11'd0,    1'b1, ST_OK,      11'd4},
        '{OP_WR_BYTE,  8'h12, 11'd0,    1'b1, ST_NOROOM,  11'd4},
        '{OP_PEEK,     8'h00, 11'd0,    1'b0, ST_OK,      11'd0},
        '{OP_POP_MANY, 8'h00, 11'd0,    1'b1, ST_OK,      11'd4},
        '{OP_POP_MANY, 8'h00, 11'd5,    1'b1, ST_EMPTY,   11'd4},
        '{OP_POP_MANY, 8'h00, 11'd3,    1'b0, ST_OK,      11'd0},
        '{OP_POP,      8'h00, 11'd0,    1'b0, ST_OK,      11'd0},
        '{OP_REWIND,   8'h00, 11'd4,    1'b1, ST_OK,      11'd4},
        '{OP_WR_BEGIN, 8'h00, 11'd1024, 1'b1, ST_NOROOM,  11'd4},
        '{OP_POP_MANY, 8'h00, 11'd4,    1'b0, ST_OK,      11'd0}
    };

    byte_ring_buffer_rewind dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // bytes held as the block reports them
    function automatic int fill_level();
        return is_full ? DEPTH : (wr_idx - rd_idx + DEPTH) % DEPTH;
    endfunction

    // room check for a write burst, including the wrap past the top of the store
    function automatic bit room_for(input int len);
        if (wr_idx < rd_idx)
            return wr_idx + len <= rd_idx;
        if (wr_idx > rd_idx) begin
            if (wr_idx + len > DEPTH)
                return len - (DEPTH - wr_idx) <= rd_idx;
            return 1'b1;
        end
        return !is_full;
    endfunction

    // shorten a rewind that would expose store entries never written since reset
    function automatic int rewind_guard(input int c);
        int room;
        int run;
        int idx;
        room = DEPTH - fill_level();
        if (c == 0 || c > DEPTH)
            return c;
        run = 0;
        idx = rd_idx;
        while (run < room) begin
            idx = (idx + DEPTH - 1) % DEPTH;
            if (!ring_stamped[idx])
                break;
            run++;
        end
        if (c <= run || run >= room)
            return c;
        return run;
    endfunction

    task automatic push_result(input logic [ST_W-1:0] st, input logic [BYTE_W-1:0] data,
                               input int done, input bit last);
        ring_rsp_t r;
        r.st   = st;
        r.data = data;
        r.done = DONE_W'(done);
        r.last = last;
        r.lvl  = LVL_W'(fill_level());
        if (item_results == 0)
            item_head = r;
        item_results++;
        due_results.push_back(r);
    endtask

    // ring buffer behavior for one accepted command transfer
    task automatic apply_ring_op(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                                 input int c);
        bit was_full;
        was_full = is_full;
        item_results = 0;
        case (op)
            OP_WR_BEGIN: begin
                if (c > DEPTH) begin
                    burst_rem = 0;
                    push_result(ST_BADLEN, '0, 0, 1'b1);
                end else if (room_for(c)) begin
                    burst_rem = c;
                    push_result(ST_OK, '0, 0, 1'b1);
                end else begin
                    burst_rem = 0;
                    push_result(ST_NOROOM, '0, 0, 1'b1);
                end
            end
            OP_WR_BYTE: begin
                if (burst_rem == 0) begin
                    push_result(ST_NOROOM, '0, 0, 1'b1);
                end else begin
                    burst_rem--;
                    if (is_full) begin
                        drops++;
                        push_result(ST_DROPPED, '0, 0, 1'b1);
                    end else begin
                        ring_mem[wr_idx]     = b;
                        ring_stamped[wr_idx] = 1'b1;
                        wr_idx = (wr_idx + 1) % DEPTH;
                        if (wr_idx == rd_idx)
                            is_full = 1'b1;
                        push_result(ST_OK, '0, 0, 1'b1);
                    end
                end
            end
            OP_PEEK, OP_POP: begin
                if (fill_level() == 0) begin
                    push_result(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    b = ring_mem[rd_idx];
                    if (op == OP_POP) begin
                        rd_idx  = (rd_idx + 1) % DEPTH;
                        is_full = 1'b0;
                    end
                    push_result(ST_OK, b, 0, 1'b1);
                end
            end
            OP_POP_MANY: begin
                if (c > MAX_BURST) begin
                    push_result(ST_BADLEN, '0, 0, 1'b1);
                end else if (fill_level() == 0 || fill_level() < c) begin
                    push_result(ST_EMPTY, '0, 0, 1'b1);
                end else if (c == 0) begin
                    // zero length with data held leaves the full flag alone
                    push_result(ST_OK, '0, 0, 1'b1);
                end else begin
                    is_full = 1'b0;
                    for (int i = 1; i <= c; i++) begin
                        b = ring_mem[rd_idx];
                        rd_idx = (rd_idx + 1) % DEPTH;
                        push_result(ST_OK, b, i, i == c);
                    end
                end
            end
            OP_REWIND: begin
                if (c > DEPTH) begin
                    push_result(ST_BADLEN, '0, 0, 1'b1);
                end else begin
                    // zero length changes nothing, not even the full flag
                    if (c > 0) begin
                        rd_idx = (rd_idx + DEPTH - c) % DEPTH;
                        if (rd_idx == wr_idx)
                            is_full = 1'b1;
                    end
                    push_result(ST_OK, '0, 0, 1'b1);
                end
            end
            default: push_result(ST_BADLEN, '0, 0, 1'b1);
        endcase
        if (is_full && !was_full)
            full_hits++;
    endtask

    // drive one command transfer, wait for it to be taken, then maybe pause
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b,
                            input int c);
        int gap;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {PAD_W'(0), CNT_W'(c), b};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_ring_op(op, b, c);
        cmds_sent++;
        if (tx_run > 0) begin
            tx_run--;
        end else begin
            tx_run = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // receiver back-pressure: modes of free flow, light, periodic and heavy stalls
    int rx_mode;
    int rx_mode_left;
    int rx_phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_mode       = 0;
            rx_mode_left  = 0;
            rx_phase      = 0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(16, 96);
            end else begin
                rx_mode_left--;
            end
            rx_phase = (rx_phase + 1) % 5;
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
                2:       m_axis_tready <= (rx_phase < 3);
                default: m_axis_tready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        ring_rsp_t e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing expected", results_checked));
            end else begin
                e = due_results.pop_front();
                if (m_axis_tuser !== e.st)
                    report_mismatch($sformatf("result %0d status %0d want %0d",
                                              results_checked, m_axis_tuser, e.st));
                if (m_axis_tdata[7:0] !== e.data)
                    report_mismatch($sformatf("result %0d rd_byte %0h want %0h",
                                              results_checked, m_axis_tdata[7:0], e.data));
                if (m_axis_tdata[14:8] !== e.done)
                    report_mismatch($sformatf("result %0d count_done %0d want %0d",
                                              results_checked, m_axis_tdata[14:8], e.done));
                if (m_axis_tlast !== e.last)
                    report_mismatch($sformatf("result %0d last %0b want %0b",
                                              results_checked, m_axis_tlast, e.last));
                if (m_axis_tdata[25:15] !== e.lvl)
                    report_mismatch($sformatf("result %0d level %0d want %0d",
                                              results_checked, m_axis_tdata[25:15], e.lvl));
            end
            results_checked++;
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] b;
        int                c;
        int                lvl;
        int                r;
        int                pick;
        int                useful;
        bit                counts;

        rd_idx = 0;
        wr_idx = 0;
        is_full = 1'b0;
        burst_rem = 0;
        mismatches = 0;
        results_checked = 0;
        cmds_sent = 0;
        full_hits = 0;
        drops = 0;
        tx_run = 0;
        idle_cycles = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // opening rows: empty reads, bad lengths, stray writes, a short burst and a rewind
        foreach (opening_rows[i]) begin
            send_cmd(opening_rows[i].op, opening_rows[i].wb, int'(opening_rows[i].cnt));
            if (opening_rows[i].typed &&
                (item_head.st !== opening_rows[i].st || item_head.lvl !== opening_rows[i].lvl))
                report_mismatch($sformatf("opening row %0d predicts status %0d level %0d",
                                          i, item_head.st, item_head.lvl));
        end

        // random part: mostly well-formed bursts and reads, with some noise
        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            lvl = fill_level();
            b   = BYTE_W'($urandom_range(0, 255));
            c   = $urandom_range(0, 2047);
            r   = $urandom_range(0, 19);
            if (burst_rem > 0 && $urandom_range(0, 9) < 8) begin
                op = OP_WR_BYTE;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 22) begin
                    op = OP_WR_BEGIN;
                    if (r == 0)      c = $urandom_range(DEPTH + 1, 2047);
                    else if (r == 1) c = 0;
                    else if (r < 4)  c = $urandom_range(0, DEPTH);
                    else if (r == 4) c = DEPTH - lvl;
                    else             c = $urandom_range(1, 32);
                end else if (pick < 32) begin
                    op = OP_PEEK;
                end else if (pick < 44) begin
                    op = OP_POP;
                end else if (pick < 66) begin
                    op = OP_POP_MANY;
                    if (r == 0)      c = $urandom_range(MAX_BURST + 1, 2047);
                    else if (r == 1) c = 0;
                    else if (r == 2) c = lvl + $urandom_range(1, 8);
                    else if (lvl == 0) c = $urandom_range(1, 8);
                    else c = $urandom_range(1, (lvl < MAX_BURST) ? lvl : MAX_BURST);
                end else if (pick < 80) begin
                    op = OP_REWIND;
                    if (r == 0)      c = $urandom_range(DEPTH + 1, 2047);
                    else if (r == 1) c = 0;
                    else if (r < 4)  c = DEPTH - lvl;
                    else if (r == 4) c = $urandom_range(0, DEPTH);
                    else             c = $urandom_range(1, 48);
                end else if (pick < 86) begin
                    op = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
                end else if (pick < 90) begin
                    op = OP_WR_BYTE;
                end else begin
                    op = OP_POP;
                end
            end
            if (op == OP_REWIND)
                c = rewind_guard(c);
            // ignored commands do not count toward the random total
            counts = !(op == OP_SPARE_6 || op == OP_SPARE_7 ||
                       (op == OP_WR_BYTE && burst_rem == 0));
            send_cmd(op, b, c);
            if (counts)
                useful++;
        end

        // closing rows: full buffer reached by a rewind, then only commands that read nothing
        send_cmd(OP_WR_BEGIN, 8'h00, 1);
        c = DEPTH - fill_level();
        send_cmd(OP_REWIND, 8'h00, c);
        send_cmd(OP_WR_BYTE, 8'hA5, 0);
        send_cmd(OP_WR_BEGIN, 8'h00, 0);
        send_cmd(OP_POP_MANY, 8'h00, 0);
        send_cmd(OP_POP_MANY, 8'h00, MAX_BURST + 1);
        send_cmd(OP_REWIND, 8'h00, 0);
        send_cmd(OP_REWIND, 8'h00, DEPTH);
        send_cmd(OP_WR_BYTE, 8'h5A, 0);

        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d commands and %0d result transfers", cmds_sent, results_checked);
        $display("buffer went full %0d times, %0d bytes dropped, %0d mismatches",
                 full_hits, drops, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
hdl/brb_pkg.sv
hdl/brb_ctrl.sv
hdl/brb_dp.sv
hdl/byte_ring_buffer_rewind.sv
test/tb_byte_ring_buffer_rewind.sv
